@@ rtl/gfq_pkg.sv @@
package gfq_pkg;

  localparam int unsigned CoordW  = 24;
  localparam int unsigned ScaledW = 20;
  localparam int unsigned PixW    = 17;
  localparam int unsigned TexW    = 17;
  localparam int unsigned SizeW   = 13;
  localparam int unsigned BitsW   = 17;
  localparam int unsigned StepW   = 5;

  localparam logic [TexW-1:0]   TexOne    = 17'h10000;
  localparam logic [CoordW-1:0] S24Max    = 24'h7FFFFF;
  localparam logic [StepW-1:0]  CellSteps = 5'd8;
  localparam logic [StepW-1:0]  TexSteps  = 5'd17;
  localparam logic [2:0]        LastCorner = 3'd5;
  localparam logic [2:0]        ReportSlot = 3'd6;

  typedef enum logic [2:0] {
    REG_GLYPH_WIDTH   = 3'd0,
    REG_GLYPH_HEIGHT  = 3'd1,
    REG_CELLS_PER_ROW = 3'd2,
    REG_FIRST_CODE    = 3'd3,
    REG_ATLAS_WIDTH   = 3'd4,
    REG_ATLAS_HEIGHT  = 3'd5,
    REG_DRAW_SCALE    = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [7:0]  glyph_width;
    logic [7:0]  glyph_height;
    logic [8:0]  cells_per_row;
    logic [7:0]  first_code;
    logic [12:0] atlas_width;
    logic [12:0] atlas_height;
    logic [11:0] draw_scale;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [SizeW-1:0] rem_init;
    logic [BitsW-1:0] bits;
    logic [SizeW-1:0] divisor;
    logic [StepW-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic             busy;
    logic [BitsW-1:0] quo;
    logic [SizeW-1:0] rem;
  } div_rsp_t;

endpackage

@@ rtl/gfq_regs.sv @@
module gfq_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output gfq_pkg::cfg_t     cfg_o
);

  gfq_pkg::cfg_t cfg_q;
  logic          wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.glyph_width   <= 8'd8;
      cfg_q.glyph_height  <= 8'd8;
      cfg_q.cells_per_row <= 9'd16;
      cfg_q.first_code    <= 8'd32;
      cfg_q.atlas_width   <= 13'd128;
      cfg_q.atlas_height  <= 13'd128;
      cfg_q.draw_scale    <= 12'd256;
    end else if (wr_en) begin
      case (gfq_pkg::reg_idx_e'(paddr[4:2]))
        gfq_pkg::REG_GLYPH_WIDTH:   cfg_q.glyph_width   <= pwdata[7:0];
        gfq_pkg::REG_GLYPH_HEIGHT:  cfg_q.glyph_height  <= pwdata[7:0];
        gfq_pkg::REG_CELLS_PER_ROW: cfg_q.cells_per_row <= pwdata[8:0];
        gfq_pkg::REG_FIRST_CODE:    cfg_q.first_code    <= pwdata[7:0];
        gfq_pkg::REG_ATLAS_WIDTH:   cfg_q.atlas_width   <= pwdata[12:0];
        gfq_pkg::REG_ATLAS_HEIGHT:  cfg_q.atlas_height  <= pwdata[12:0];
        gfq_pkg::REG_DRAW_SCALE:    cfg_q.draw_scale    <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (gfq_pkg::reg_idx_e'(paddr[4:2]))
      gfq_pkg::REG_GLYPH_WIDTH:   prdata = {24'd0, cfg_q.glyph_width};
      gfq_pkg::REG_GLYPH_HEIGHT:  prdata = {24'd0, cfg_q.glyph_height};
      gfq_pkg::REG_CELLS_PER_ROW: prdata = {23'd0, cfg_q.cells_per_row};
      gfq_pkg::REG_FIRST_CODE:    prdata = {24'd0, cfg_q.first_code};
      gfq_pkg::REG_ATLAS_WIDTH:   prdata = {19'd0, cfg_q.atlas_width};
      gfq_pkg::REG_ATLAS_HEIGHT:  prdata = {19'd0, cfg_q.atlas_height};
      gfq_pkg::REG_DRAW_SCALE:    prdata = {20'd0, cfg_q.draw_scale};
      default:                    prdata = '0;
    endcase
  end

endmodule

@@ rtl/gfq_div.sv @@
module gfq_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gfq_pkg::div_req_t   req_i,
  output gfq_pkg::div_rsp_t   rsp_o
);

  logic                                busy_q;
  logic                                done_q;
  logic [gfq_pkg::StepW-1:0]           cnt_q;
  logic [gfq_pkg::SizeW-1:0]           rem_q;
  logic [gfq_pkg::SizeW-1:0]           dvs_q;
  logic [gfq_pkg::BitsW-1:0]           sh_q;
  logic [gfq_pkg::BitsW-1:0]           quo_q;
  logic [gfq_pkg::SizeW:0]             trial;
  logic [gfq_pkg::SizeW:0]             diff;
  logic                                ge;
  logic [gfq_pkg::SizeW-1:0]           rem_d;

  // one restoring step per cycle, remainder always below the divisor
  assign trial = {rem_q, sh_q[gfq_pkg::BitsW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = trial >= {1'b0, dvs_q};
  assign rem_d = ge ? diff[gfq_pkg::SizeW-1:0] : trial[gfq_pkg::SizeW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == gfq_pkg::StepW'(1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - gfq_pkg::StepW'(1);
        if (cnt_q == gfq_pkg::StepW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.rem_init;
      sh_q  <= req_i.bits;
      dvs_q <= req_i.divisor;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      sh_q  <= {sh_q[gfq_pkg::BitsW-2:0], 1'b0};
      quo_q <= {quo_q[gfq_pkg::BitsW-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.busy = busy_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

@@ rtl/grid_font_glyph_quad_generator.sv @@
// A code rejected before the cell lookup goes straight to the position step; one past the
// last row first passes the cell division and row check. Otherwise the quad follows these,
// the four texture coordinates (at most 4 need a division, the rest saturate to one) and
// the position step; results then go one per cycle while out_ready_i is high. One request
// at a time: the next is taken the cycle after its last result.
// Reset (rst_ni low, async) clears the cursor and sequencer and loads register defaults.
module grid_font_glyph_quad_generator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         char_code_i,
  input  logic               first_of_string_i,
  input  logic signed [23:0] start_x_i,
  input  logic signed [23:0] base_y_i,
  input  logic signed [23:0] depth_z_i,
  input  logic [31:0]        rgba_color_i,
  input  logic               end_of_string_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               result_kind_o,
  output logic signed [23:0] vertex_x_o,
  output logic signed [23:0] vertex_y_o,
  output logic signed [23:0] vertex_z_o,
  output logic [16:0]        tex_u_o,
  output logic [16:0]        tex_v_o,
  output logic [31:0]        vertex_color_o,
  output logic [2:0]         corner_index_o,
  output logic signed [23:0] cursor_after_o,
  output logic               last_of_run_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CELL,
    ST_CHK,
    ST_TEXS,
    ST_TEXW,
    ST_POS,
    ST_EMIT
  } state_e;

  gfq_pkg::cfg_t     cfg;
  gfq_pkg::div_req_t div_req;
  gfq_pkg::div_rsp_t div_rsp;

  state_e      state_q, state_d;
  logic [2:0]  emit_q, emit_d;
  logic [1:0]  k_q, k_d;
  logic        found_q, found_d;
  logic [23:0] cursor_q, cursor_d;

  logic [23:0] x0_q, y0_q, z_q, y1_q;
  logic [31:0] color_q;
  logic        end_q;
  logic [gfq_pkg::ScaledW-1:0] adv_q, sh_q;
  logic [15:0] px_q, py_q;
  logic [3:0][gfq_pkg::TexW-1:0] tex_q;

  logic        ld_in, ld_cell, ld_tex, ld_pos;
  logic [gfq_pkg::TexW-1:0] tex_val;
  logic        lookup_ok;
  logic [7:0]  idx;
  logic [gfq_pkg::PixW-1:0] pix_sel;
  logic [gfq_pkg::SizeW-1:0] size_sel;
  logic        pix_sat;
  logic [gfq_pkg::PixW-1:0] row_end;
  logic [24:0] sum_x, sum_y;
  logic [23:0] x1, y1;
  logic        vis;
  logic        is_rep, hi_x, hi_y;

  gfq_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  gfq_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign lookup_ok = (|cfg.glyph_width) && (|cfg.glyph_height) && (|cfg.cells_per_row) &&
                     (|cfg.atlas_width) && (|cfg.atlas_height) &&
                     (char_code_i >= cfg.first_code);
  assign idx = char_code_i - cfg.first_code;

  // glyph row fits the atlas when its bottom edge stays inside
  assign row_end = {1'b0, py_q} + gfq_pkg::PixW'(cfg.glyph_height);

  always_comb begin
    case (k_q)
      2'd0:    pix_sel = {1'b0, px_q};
      2'd1:    pix_sel = {1'b0, px_q} + gfq_pkg::PixW'(cfg.glyph_width);
      2'd2:    pix_sel = {1'b0, py_q};
      default: pix_sel = row_end;
    endcase
  end

  assign size_sel = k_q[1] ? cfg.atlas_height : cfg.atlas_width;
  assign pix_sat  = pix_sel >= gfq_pkg::PixW'(size_sel);

  assign sum_x = {x0_q[23], x0_q} + 25'(adv_q);
  assign sum_y = {y0_q[23], y0_q} + 25'(sh_q);
  assign x1    = (!sum_x[24] && sum_x[23]) ? gfq_pkg::S24Max : sum_x[23:0];
  assign y1    = (!sum_y[24] && sum_y[23]) ? gfq_pkg::S24Max : sum_y[23:0];
  assign vis   = found_q && (tex_q[1] > tex_q[0]) && (tex_q[3] > tex_q[2]);

  always_comb begin
    state_d   = state_q;
    emit_d    = emit_q;
    k_d       = k_q;
    found_d   = found_q;
    cursor_d  = cursor_q;
    div_req   = '0;
    ld_in     = 1'b0;
    ld_cell   = 1'b0;
    ld_tex    = 1'b0;
    ld_pos    = 1'b0;
    tex_val   = div_rsp.quo;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ld_in   = 1'b1;
          found_d = 1'b0;
          if (lookup_ok) begin
            div_req.start    = 1'b1;
            div_req.rem_init = '0;
            div_req.bits     = {idx, 9'd0};
            div_req.divisor  = gfq_pkg::SizeW'(cfg.cells_per_row);
            div_req.steps    = gfq_pkg::CellSteps;
            state_d          = ST_CELL;
          end else begin
            state_d = ST_POS;
          end
        end
      end
      ST_CELL: begin
        if (div_rsp.done) begin
          ld_cell = 1'b1;
          state_d = ST_CHK;
        end
      end
      ST_CHK: begin
        k_d = 2'd0;
        if (row_end <= gfq_pkg::PixW'(cfg.atlas_height)) begin
          found_d = 1'b1;
          state_d = ST_TEXS;
        end else begin
          state_d = ST_POS;
        end
      end
      ST_TEXS: begin
        if (pix_sat) begin
          ld_tex  = 1'b1;
          tex_val = gfq_pkg::TexOne;
          k_d     = k_q + 2'd1;
          state_d = (k_q == 2'd3) ? ST_POS : ST_TEXS;
        end else begin
          div_req.start    = 1'b1;
          div_req.rem_init = gfq_pkg::SizeW'(pix_sel[12:1]);
          div_req.bits     = {pix_sel[0], 4'd0, size_sel[12:1]};
          div_req.divisor  = size_sel;
          div_req.steps    = gfq_pkg::TexSteps;
          state_d          = ST_TEXW;
        end
      end
      ST_TEXW: begin
        if (div_rsp.done) begin
          ld_tex  = 1'b1;
          k_d     = k_q + 2'd1;
          state_d = (k_q == 2'd3) ? ST_POS : ST_TEXS;
        end
      end
      ST_POS: begin
        ld_pos   = 1'b1;
        cursor_d = x1;
        if (vis || end_q) begin
          emit_d  = vis ? 3'd0 : gfq_pkg::ReportSlot;
          state_d = ST_EMIT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_ready_i) begin
          if (last_of_run_o) begin
            state_d = ST_IDLE;
          end else if (emit_q == gfq_pkg::LastCorner) begin
            emit_d = gfq_pkg::ReportSlot;
          end else begin
            emit_d = emit_q + 3'd1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      emit_q   <= '0;
      k_q      <= '0;
      found_q  <= 1'b0;
      cursor_q <= '0;
    end else begin
      state_q  <= state_d;
      emit_q   <= emit_d;
      k_q      <= k_d;
      found_q  <= found_d;
      cursor_q <= cursor_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_in) begin
      x0_q    <= first_of_string_i ? start_x_i : cursor_q;
      y0_q    <= base_y_i;
      z_q     <= depth_z_i;
      color_q <= rgba_color_i;
      end_q   <= end_of_string_i;
      adv_q   <= gfq_pkg::ScaledW'(cfg.glyph_width) * gfq_pkg::ScaledW'(cfg.draw_scale);
      sh_q    <= gfq_pkg::ScaledW'(cfg.glyph_height) * gfq_pkg::ScaledW'(cfg.draw_scale);
    end
    if (ld_cell) begin
      px_q <= 16'(div_rsp.rem[7:0]) * 16'(cfg.glyph_width);
      py_q <= 16'(div_rsp.quo[7:0]) * 16'(cfg.glyph_height);
    end
    if (ld_tex) begin
      tex_q[k_q] <= tex_val;
    end
    if (ld_pos) begin
      y1_q <= y1;
    end
  end

  // corners 1, 3, 4 take the right edge; 2, 4, 5 the bottom edge
  assign is_rep = emit_q == gfq_pkg::ReportSlot;
  assign hi_x   = (emit_q == 3'd1) || (emit_q == 3'd3) || (emit_q == 3'd4);
  assign hi_y   = (emit_q == 3'd2) || (emit_q == 3'd4) || (emit_q == 3'd5);

  assign in_ready_o     = state_q == ST_IDLE;
  assign out_valid_o    = state_q == ST_EMIT;
  assign result_kind_o  = is_rep;
  assign vertex_x_o     = is_rep ? '0 : (hi_x ? cursor_q : x0_q);
  assign vertex_y_o     = is_rep ? '0 : (hi_y ? y1_q : y0_q);
  assign vertex_z_o     = is_rep ? '0 : z_q;
  assign tex_u_o        = is_rep ? '0 : (hi_x ? tex_q[1] : tex_q[0]);
  assign tex_v_o        = is_rep ? '0 : (hi_y ? tex_q[3] : tex_q[2]);
  assign vertex_color_o = is_rep ? '0 : color_q;
  assign corner_index_o = is_rep ? '0 : emit_q;
  assign cursor_after_o = cursor_q;
  assign last_of_run_o  = is_rep || ((emit_q == gfq_pkg::LastCorner) && !end_q);

`ifndef SYNTHESIS
  a_ready_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("request taken while results pending");

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

  a_cursor_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && $past(out_valid_o)) |-> $stable(cursor_q))
    else $error("cursor moved during result delivery");

  a_report_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_kind_o) |-> last_of_run_o)
    else $error("cursor report not last of run");
`endif

endmodule
